[src/bxiou_pkg.sv]
// Package for the box IoU block: widths, item field types, stage tag type,
// register indexes and the edge helper functions.
// No dependencies.
`default_nettype none

package bxiou_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int COORD_FRAC_BITS = 4;
   localparam int IOU_FRAC_BITS   = 16;

   localparam int IOU_WIDTH   = IOU_FRAC_BITS + 1;
   // edges in half-LSB units: 2*center +/- size
   localparam int EDGE_W      = COORD_WIDTH + 3;
   localparam int EXT_W       = COORD_WIDTH + 5;
   localparam int PROD_W      = 2 * EXT_W;
   localparam int AREA_W      = 2 * EXT_W - 2;
   localparam int DIV_W       = AREA_W + 1;
   localparam int CSR_INDEX_W = 3;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [IOU_WIDTH-1:0]   iou_type;

   localparam iou_type IOU_FULL = {1'b1, {IOU_FRAC_BITS{1'b0}}};
   localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(2 ** (COORD_FRAC_BITS + 1));

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_X0,
      CSR_REF_Y0,
      CSR_REF_X1,
      CSR_REF_Y1,
      CSR_CENTER_MODE
   } csr_index_type;

   typedef struct packed {
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] top;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] bottom;
   } edges_type;

   typedef struct packed {
      logic valid;
      logic bad;
      logic sat;
      logic last;
   } tag_type;

   function automatic edges_type box_edges(coord_type a, coord_type b, coord_type c,
                                           coord_type d, logic center);
      logic signed [EDGE_W-1:0] a2;
      logic signed [EDGE_W-1:0] b2;
      logic signed [EDGE_W-1:0] c2;
      logic signed [EDGE_W-1:0] d2;
      logic signed [EDGE_W-1:0] c1;
      logic signed [EDGE_W-1:0] d1;
      edges_type e;
      a2 = signed'({2'b00, a, 1'b0});
      b2 = signed'({2'b00, b, 1'b0});
      c2 = signed'({2'b00, c, 1'b0});
      d2 = signed'({2'b00, d, 1'b0});
      c1 = signed'({3'b000, c});
      d1 = signed'({3'b000, d});
      if (center) begin
         e.left   = a2 - c1;
         e.right  = a2 + c1;
         e.top    = b2 - d1;
         e.bottom = b2 + d1;
      end else begin
         e.left   = a2;
         e.top    = b2;
         e.right  = c2;
         e.bottom = d2;
      end
      return e;
   endfunction

   function automatic logic signed [EXT_W-1:0] ext(logic signed [EDGE_W-1:0] v);
      return {{(EXT_W - EDGE_W){v[EDGE_W-1]}}, v};
   endfunction

endpackage

`default_nettype wire

[src/bxiou_if.sv]
// Channel interfaces of the box IoU block: input boxes, IoU results and
// register writes. Depends on bxiou_pkg.
`default_nettype none

interface bxiou_req_if import bxiou_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type box_x0;
   coord_type box_y0;
   coord_type box_x1;
   coord_type box_y1;
   logic      last;

   modport source (output valid, box_x0, box_y0, box_x1, box_y1, last, input ready);
   modport sink   (input valid, box_x0, box_y0, box_x1, box_y1, last, output ready);
endinterface

interface bxiou_rsp_if import bxiou_pkg::*; ();
   logic    valid;
   logic    ready;
   iou_type iou;
   logic    bad_union;
   logic    last_out;

   modport source (output valid, iou, bad_union, last_out, input ready);
   modport sink   (input valid, iou, bad_union, last_out, output ready);
endinterface

interface bxiou_csr_if import bxiou_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   coord_type              data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/bxiou_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, then round to
// nearest (ties up), cap at 1.0 and apply the saturate / bad-union flags.
// Depends on bxiou_pkg.
`default_nettype none

module bxiou_divider import bxiou_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire tag_type          in_tag,
   input  wire logic [DIV_W-1:0] in_rem,
   input  wire logic [DIV_W-1:0] in_dvsr,
   output tag_type               out_tag,
   output iou_type               out_iou
);

   tag_type                  tag_ff  [0:IOU_FRAC_BITS-1];
   logic [DIV_W-1:0]         rem_ff  [0:IOU_FRAC_BITS-1];
   logic [DIV_W-1:0]         dvsr_ff [0:IOU_FRAC_BITS-1];
   logic [IOU_FRAC_BITS-1:0] q_ff    [0:IOU_FRAC_BITS-1];

   for (genvar i = 0; i < IOU_FRAC_BITS; i++) begin : g_step
      tag_type                  tag_prev;
      logic [DIV_W-1:0]         rem_prev;
      logic [DIV_W-1:0]         dvsr_prev;
      logic [IOU_FRAC_BITS-1:0] q_prev;
      logic [DIV_W-1:0]         rem_sh;
      logic                     take;
      logic [DIV_W-1:0]         rem_in;
      logic [IOU_FRAC_BITS-1:0] q_in;

      if (i == 0) begin : g_first
         assign tag_prev  = in_tag;
         assign rem_prev  = in_rem;
         assign dvsr_prev = in_dvsr;
         assign q_prev    = '0;
      end else begin : g_next
         assign tag_prev  = tag_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign dvsr_prev = dvsr_ff[i-1];
         assign q_prev    = q_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_prev[DIV_W-2:0], 1'b0};
         take   = rem_sh >= dvsr_prev;
         rem_in = take ? rem_sh - dvsr_prev : rem_sh;
         q_in   = {q_prev[IOU_FRAC_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (en) begin
            tag_ff[i] <= tag_prev;
         end
         if (en) begin
            rem_ff[i]  <= rem_in;
            dvsr_ff[i] <= dvsr_prev;
            q_ff[i]    <= q_in;
         end
      end
   end

   logic    round_up;
   iou_type q_rnd;

   always_comb begin
      round_up = {rem_ff[IOU_FRAC_BITS-1], 1'b0} >= {1'b0, dvsr_ff[IOU_FRAC_BITS-1]};
      q_rnd    = {1'b0, q_ff[IOU_FRAC_BITS-1]} + IOU_WIDTH'(round_up);
      out_tag  = tag_ff[IOU_FRAC_BITS-1];
      if (out_tag.bad) begin
         out_iou = '0;
      end else if (out_tag.sat || q_rnd > IOU_FULL) begin
         out_iou = IOU_FULL;
      end else begin
         out_iou = q_rnd;
      end
   end

endmodule

`default_nettype wire

[src/box_iou_one_to_many.sv]
// Top level of the box IoU block: register file, edge / extent / area / union
// stages, divider, output register. Depends on bxiou_pkg, bxiou_if, bxiou_divider.
//
// Usage: write the reference box (index 0..3) and center_mode (index 4)
// through csr_if while no box is in flight; csr_if.ready is always high and
// writes to other indexes are dropped. Then stream boxes on req_if, one item
// per cycle. Each box gives one item on rsp_if: iou in Q1.16 (65536 = 1.0),
// bad_union when the union area is not positive, and the box's last flag.
// A box accepted on req_if passes the 4 front stages, one divider stage per
// quotient bit and the output register before it shows on rsp_if.
// One box per cycle while rsp_if does not stall it, since the single
// pipeline advances as a whole.
// When rsp_if.ready is low while a result waits, the whole pipeline holds
// and req_if.ready drops; nothing is lost or repeated.
// Reset clears the registers to 0 (corner form) and empties the pipeline.
`default_nettype none

module box_iou_one_to_many import bxiou_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   bxiou_req_if.sink   req_if,
   bxiou_rsp_if.source rsp_if,
   bxiou_csr_if.sink   csr_if
);

   // registers
   coord_type ref_x0_ff, ref_y0_ff, ref_x1_ff, ref_y1_ff;
   logic      center_mode_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x0_ff      <= '0;
         ref_y0_ff      <= '0;
         ref_x1_ff      <= '0;
         ref_y1_ff      <= '0;
         center_mode_ff <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_REF_X0:      ref_x0_ff      <= csr_if.data;
            CSR_REF_Y0:      ref_y0_ff      <= csr_if.data;
            CSR_REF_X1:      ref_x1_ff      <= csr_if.data;
            CSR_REF_Y1:      ref_y1_ff      <= csr_if.data;
            CSR_CENTER_MODE: center_mode_ff <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   edges_type ref_edges;
   assign ref_edges = box_edges(ref_x0_ff, ref_y0_ff, ref_x1_ff, ref_y1_ff, center_mode_ff);

   logic    en;
   logic    rsp_valid_ff;
   iou_type rsp_iou_ff;
   logic    rsp_bad_ff;
   logic    rsp_last_ff;

   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1: box edges
   tag_type   s1_tag_ff;
   edges_type s1_box_ff;
   tag_type   s1_tag_in;

   always_comb begin
      s1_tag_in       = '0;
      s1_tag_in.valid = req_if.valid;
      s1_tag_in.last  = req_if.last;
   end

   // stage 2: overlap and box extents
   tag_type                  s2_tag_ff;
   logic signed [EXT_W-1:0]  s2_ix_ff, s2_iy_ff, s2_rw_ff, s2_rh_ff, s2_bw_ff, s2_bh_ff;
   logic signed [EDGE_W-1:0] min_r, max_l, min_b, max_t;
   logic signed [EXT_W-1:0]  ix_raw, iy_raw;
   logic signed [EXT_W-1:0]  s2_ix_in, s2_iy_in, s2_rw_in, s2_rh_in, s2_bw_in, s2_bh_in;

   always_comb begin
      min_r    = (ref_edges.right < s1_box_ff.right) ? ref_edges.right : s1_box_ff.right;
      max_l    = (ref_edges.left > s1_box_ff.left) ? ref_edges.left : s1_box_ff.left;
      min_b    = (ref_edges.bottom < s1_box_ff.bottom) ? ref_edges.bottom : s1_box_ff.bottom;
      max_t    = (ref_edges.top > s1_box_ff.top) ? ref_edges.top : s1_box_ff.top;
      ix_raw   = ext(min_r) - ext(max_l) + ONE_EXT;
      iy_raw   = ext(min_b) - ext(max_t) + ONE_EXT;
      s2_ix_in = ix_raw[EXT_W-1] ? '0 : ix_raw;
      s2_iy_in = iy_raw[EXT_W-1] ? '0 : iy_raw;
      s2_rw_in = ext(ref_edges.right) - ext(ref_edges.left) + ONE_EXT;
      s2_rh_in = ext(ref_edges.bottom) - ext(ref_edges.top) + ONE_EXT;
      s2_bw_in = ext(s1_box_ff.right) - ext(s1_box_ff.left) + ONE_EXT;
      s2_bh_in = ext(s1_box_ff.bottom) - ext(s1_box_ff.top) + ONE_EXT;
   end

   // stage 3: areas
   tag_type                  s3_tag_ff;
   logic signed [AREA_W-1:0] s3_inter_ff, s3_area_r_ff, s3_area_b_ff;
   logic signed [PROD_W-1:0] prod_i, prod_r, prod_b;

   always_comb begin
      prod_i = s2_ix_ff * s2_iy_ff;
      prod_r = s2_rw_ff * s2_rh_ff;
      prod_b = s2_bw_ff * s2_bh_ff;
   end

   // stage 4: union, flags, divider operands
   tag_type                  s4_tag_ff;
   logic [DIV_W-1:0]         s4_rem_ff, s4_dvsr_ff;
   logic signed [AREA_W-1:0] uni;
   tag_type                  s4_tag_in;
   logic [DIV_W-1:0]         s4_rem_in, s4_dvsr_in;

   always_comb begin
      uni           = s3_area_r_ff + s3_area_b_ff - s3_inter_ff;
      s4_tag_in     = s3_tag_ff;
      s4_tag_in.bad = uni[AREA_W-1] || (uni == '0);
      s4_tag_in.sat = !s4_tag_in.bad && (s3_inter_ff >= uni);
      if (s4_tag_in.bad || s4_tag_in.sat) begin
         s4_rem_in  = '0;
         s4_dvsr_in = DIV_W'(1);
      end else begin
         s4_rem_in  = {1'b0, s3_inter_ff};
         s4_dvsr_in = {1'b0, uni};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
      end else if (en) begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s4_tag_in;
      end
      if (en) begin
         s1_box_ff    <= box_edges(req_if.box_x0, req_if.box_y0, req_if.box_x1,
                                   req_if.box_y1, center_mode_ff);
         s2_ix_ff     <= s2_ix_in;
         s2_iy_ff     <= s2_iy_in;
         s2_rw_ff     <= s2_rw_in;
         s2_rh_ff     <= s2_rh_in;
         s2_bw_ff     <= s2_bw_in;
         s2_bh_ff     <= s2_bh_in;
         s3_inter_ff  <= prod_i[AREA_W-1:0];
         s3_area_r_ff <= prod_r[AREA_W-1:0];
         s3_area_b_ff <= prod_b[AREA_W-1:0];
         s4_rem_ff    <= s4_rem_in;
         s4_dvsr_ff   <= s4_dvsr_in;
      end
   end

   tag_type div_tag;
   iou_type div_iou;

   bxiou_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (s4_tag_ff),
      .in_rem  (s4_rem_ff),
      .in_dvsr (s4_dvsr_ff),
      .out_tag (div_tag),
      .out_iou (div_iou)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_tag.valid;
      end
      if (en) begin
         rsp_iou_ff  <= div_iou;
         rsp_bad_ff  <= div_tag.bad;
         rsp_last_ff <= div_tag.last;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.iou       = rsp_iou_ff;
   assign rsp_if.bad_union = rsp_bad_ff;
   assign rsp_if.last_out  = rsp_last_ff;

endmodule

`default_nettype wire

[src/bxiou_checker.sv]
// Port-level checks for box_iou_one_to_many, attached by the bind below.
// Depends on bxiou_pkg.
`default_nettype none

module bxiou_checker import bxiou_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire iou_type rsp_iou,
   input wire logic    rsp_bad_union,
   input wire logic    rsp_last_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_iou)
         && $stable(rsp_bad_union) && $stable(rsp_last_out))
      else $error("result item changed while stalled");

   a_iou_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_iou <= IOU_FULL)
      else $error("iou above 1.0");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_union |-> rsp_iou == '0)
      else $error("bad union with nonzero iou");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind box_iou_one_to_many bxiou_checker u_bxiou_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_iou       (rsp_if.iou),
   .rsp_bad_union (rsp_if.bad_union),
   .rsp_last_out  (rsp_if.last_out)
);

`default_nettype wire
